// ----- rtl/marquee_entry_scroller_defines.svh -----
// ----------------------------------------------------------------------------
// Marquee entry scroller assertion macros
// Shared helpers for concurrent checks, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MARQUEE_ENTRY_SCROLLER_DEFINES_SVH
`define MARQUEE_ENTRY_SCROLLER_DEFINES_SVH

// Same-cycle implication on clk, disabled while arst_n is low.
`define MES_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("marquee entry scroller check failed");

// Next-cycle implication on clk, disabled while arst_n is low.
`define MES_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("marquee entry scroller check failed");

`endif

// ----- rtl/mes_pkg.sv -----
// ----------------------------------------------------------------------------
// Marquee entry scroller package
// Field widths, register indexes, codes, the entry type and the state type.
// ----------------------------------------------------------------------------
`default_nettype none

package mes_pkg;

	localparam int LETTER_W = 8;
	localparam int POS_W    = 13;
	localparam int WW_W     = 11;
	localparam int SP_W     = 7;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 32;

	// Register indexes, taken from paddr[2].
	localparam logic [0:0] REG_WINDOW_WIDTH   = 1'b0;
	localparam logic [0:0] REG_LETTER_SPACING = 1'b1;

	// Item kinds.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SCROLL = 1'b1;

	// A zero letter code inserts nothing.
	localparam logic [LETTER_W-1:0] LETTER_NONE = 8'h00;

	// Appended positions saturate here.
	localparam logic signed [POS_W:0] POS_SAT = 14'sd4095;

	// Register reset values.
	localparam logic [WW_W-1:0] WW_RESET = 11'd320;
	localparam logic [SP_W-1:0] SP_RESET = 7'd24;

	typedef struct packed {
		logic [LETTER_W-1:0]     letter;
		logic signed [POS_W-1:0] pos;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_EMIT,
		ST_SCROLL,
		ST_SCR_FIN
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/mes_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mes_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/marquee_entry_scroller.sv -----
// ----------------------------------------------------------------------------
// Marquee entry scroller
// Ordered list of scrolling letters kept as a ring in one RAM; each item lists
// it oldest first, after appending a nonzero insert letter or while scrolling.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                      Payload
//  -------   ---------------------------    ---------------------------------
//  command   start & !busy                  kind, letter
//  result    out_valid (one cycle)          out_letter, out_position,
//                                           last_entry, list_empty
//  config    psel & penable & pwrite        paddr, pwdata (prdata on reads)
//
// Busy stays high for the whole of an item while the single RAM read port walks
// the ring one entry a cycle. Each result word leaves through an output
// register in the cycle after it is formed.
// Reset zeroes the entry count, pointers and valid flags and loads the
// config registers with their reset values; the RAM needs no clearing.
// Results leave at most one per cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "marquee_entry_scroller_defines.svh"

module marquee_entry_scroller
	import mes_pkg::*;
#(
	parameter int MAX_ENTRIES = 24
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       kind,
	input  wire logic [LETTER_W-1:0]        letter,
	output logic                            out_valid,
	output logic      [LETTER_W-1:0]        out_letter,
	output logic signed [POS_W-1:0]         out_position,
	output logic                            last_entry,
	output logic                            list_empty,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [CFG_AW-1:0]          paddr,
	input  wire logic [CFG_DW-1:0]          pwdata,
	output logic      [CFG_DW-1:0]          prdata,
	output logic                            pready
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	// Ring pointer helpers.
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(MAX_ENTRIES - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(MAX_ENTRIES - 1) : p - 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [CW-1:0] c);
		logic [CW:0] s;
		s = {1'b0, CW'(p)} + {1'b0, c};
		if (s >= (CW + 1)'(MAX_ENTRIES)) begin
			s = s - (CW + 1)'(MAX_ENTRIES);
		end
		return AW'(s);
	endfunction

	state_t state_q, state_d;

	logic [WW_W-1:0] ww_q;
	logic [SP_W-1:0] sp_q;

	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] iss_q;
	logic [AW-1:0] wp_q;
	logic [CW-1:0] kept_q;
	logic          pend_vld_q;
	logic          rd_vld_s1;
	logic          rd_last_s1;

	logic [LETTER_W-1:0] letter_q;
	entry_t              pend_q;

	logic          accept;
	logic          issue;
	logic          full;
	logic          keep;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_wdata;
	entry_t        ram_rdata;

	logic signed [POS_W:0] tail_ext;
	logic signed [POS_W:0] ww_ext;
	logic signed [POS_W:0] start_pos;
	logic signed [POS_W:0] scr_pos;
	logic signed [POS_W:0] scr_limit;

	logic                    res_vld;
	logic [LETTER_W-1:0]     res_letter;
	logic signed [POS_W-1:0] res_pos;
	logic                    res_last;
	logic                    res_empty;

	logic                    out_valid_q;
	logic [LETTER_W-1:0]     out_letter_q;
	logic signed [POS_W-1:0] out_pos_q;
	logic                    out_last_q;
	logic                    out_empty_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CW'(MAX_ENTRIES));
	assign pready = 1'b1;

	// Entry storage: one RAM holding the ring of letters and positions.
	mes_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Append position: window edge, or spacing past the last entry when it lies beyond, saturated at POS_SAT.
	always_comb begin
		tail_ext = {ram_rdata.pos[POS_W-1], ram_rdata.pos};
		ww_ext   = $signed({3'b000, ww_q});
		start_pos = ww_ext;
		if (count_q != '0 && tail_ext > ww_ext) begin
			start_pos = tail_ext + $signed({7'b0000000, sp_q});
		end
		if (start_pos > POS_SAT) begin
			start_pos = POS_SAT;
		end
	end

	// Scroll step: move one pixel left, keep it while at or above the margin.
	assign scr_pos   = $signed({ram_rdata.pos[POS_W-1], ram_rdata.pos}) - 14'sd1;
	assign scr_limit = -$signed({7'b0000000, sp_q});
	assign keep      = (scr_pos >= scr_limit);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM access and the result word of this cycle.
	always_comb begin
		state_d    = state_q;
		issue      = 1'b0;
		ram_raddr  = rp_q;
		ram_we     = 1'b0;
		ram_waddr  = tail_q;
		ram_wdata  = '0;
		res_vld    = 1'b0;
		res_letter = '0;
		res_pos    = '0;
		res_last   = 1'b0;
		res_empty  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_SCROLL) begin
						state_d = ST_SCROLL;
					end else if (letter != LETTER_NONE) begin
						state_d = ST_INS_RD;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_INS_RD: begin
				ram_raddr = ptr_dec(tail_q);
				state_d   = ST_INS_WR;
			end
			ST_INS_WR: begin
				ram_we           = 1'b1;
				ram_waddr        = tail_q;
				ram_wdata.letter = letter_q;
				ram_wdata.pos    = start_pos[POS_W-1:0];
				state_d          = ST_EMIT;
			end
			ST_EMIT: begin
				if (count_q == '0) begin
					res_vld   = 1'b1;
					res_empty = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					issue = (iss_q != count_q);
					if (rd_vld_s1) begin
						res_vld    = 1'b1;
						res_letter = ram_rdata.letter;
						res_pos    = ram_rdata.pos;
						res_last   = rd_last_s1;
						if (rd_last_s1) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_SCROLL: begin
				issue = (iss_q != count_q);
				if (count_q == '0) begin
					state_d = ST_SCR_FIN;
				end
				if (rd_vld_s1) begin
					if (keep) begin
						ram_we           = 1'b1;
						ram_waddr        = wp_q;
						ram_wdata.letter = ram_rdata.letter;
						ram_wdata.pos    = scr_pos[POS_W-1:0];
						// A kept entry follows, so the held one is not the last.
						if (pend_vld_q) begin
							res_vld    = 1'b1;
							res_letter = pend_q.letter;
							res_pos    = pend_q.pos;
						end
					end
					if (rd_last_s1) begin
						state_d = ST_SCR_FIN;
					end
				end
			end
			ST_SCR_FIN: begin
				res_vld = 1'b1;
				if (pend_vld_q) begin
					res_letter = pend_q.letter;
					res_pos    = pend_q.pos;
					res_last   = 1'b1;
				end else begin
					res_empty = 1'b1;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Ring pointers, counters and the read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			rp_q        <= '0;
			iss_q       <= '0;
			wp_q        <= '0;
			kept_q      <= '0;
			pend_vld_q  <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1   <= issue;
			rd_last_s1  <= (iss_q == count_q - 1'b1);
			out_valid_q <= res_vld;
			if (accept) begin
				rp_q       <= head_q;
				iss_q      <= '0;
				wp_q       <= head_q;
				kept_q     <= '0;
				pend_vld_q <= 1'b0;
			end
			if (issue) begin
				rp_q  <= ptr_inc(rp_q);
				iss_q <= iss_q + 1'b1;
			end
			if (state_q == ST_INS_WR) begin
				tail_q <= ptr_inc(tail_q);
				iss_q  <= '0;
				if (full) begin
					head_q <= ptr_inc(head_q);
					rp_q   <= ptr_inc(head_q);
				end else begin
					count_q <= count_q + 1'b1;
					rp_q    <= head_q;
				end
			end
			if (state_q == ST_SCROLL && rd_vld_s1 && keep) begin
				wp_q       <= ptr_inc(wp_q);
				kept_q     <= kept_q + 1'b1;
				pend_vld_q <= 1'b1;
			end
			if (state_q == ST_SCR_FIN) begin
				count_q <= kept_q;
				tail_q  <= wp_q;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ww_q <= WW_RESET;
			sp_q <= SP_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2:2])
				REG_WINDOW_WIDTH:   ww_q <= pwdata[WW_W-1:0];
				REG_LETTER_SPACING: sp_q <= pwdata[SP_W-1:0];
				default:            ;
			endcase
		end
	end

	// Register read data.
	always_comb begin
		unique case (paddr[2:2])
			REG_WINDOW_WIDTH:   prdata = CFG_DW'(ww_q);
			REG_LETTER_SPACING: prdata = CFG_DW'(sp_q);
			default:            prdata = '0;
		endcase
	end

	// Payload registers: command letter, held scroll entry and result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			letter_q <= letter;
		end
		if (state_q == ST_SCROLL && rd_vld_s1 && keep) begin
			pend_q.letter <= ram_rdata.letter;
			pend_q.pos    <= scr_pos[POS_W-1:0];
		end
		out_letter_q <= res_letter;
		out_pos_q    <= res_pos;
		out_last_q   <= res_last;
		out_empty_q  <= res_empty;
	end

	assign out_valid    = out_valid_q;
	assign out_letter   = out_letter_q;
	assign out_position = out_pos_q;
	assign last_entry   = out_last_q;
	assign list_empty   = out_empty_q;

	// Checks on the ring bookkeeping and the sequencer.
	`MES_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_ENTRIES))
	`MES_ASSERT_IMP(a_ring_consistent, state_q == ST_IDLE, ptr_add(head_q, count_q) == tail_q)
	`MES_ASSERT_NXT(a_accept_busy, accept, busy)
	`MES_ASSERT_IMP(a_write_states, ram_we, state_q == ST_INS_WR || state_q == ST_SCROLL)
	`MES_ASSERT_IMP(a_kept_bound, state_q == ST_SCR_FIN, kept_q <= count_q)

endmodule

`default_nettype wire
